### hdl/fmar_pkg.sv
// Package for the fraction multiply, add and reduce block.
// Holds the widths, the controller state type and the command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fmar_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int NUM_OUT_W = 32;
  localparam int DEN_OUT_W = 30;
  localparam int EXT_W = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_PROD,
    ST_MUL_CROSS,
    ST_SETUP,
    ST_GCD,
    ST_DIV,
    ST_FINISH
  } fmar_state_t;

  typedef struct packed {
    logic load;
    logic mul_prod;
    logic mul_cross;
    logic setup;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic finish;
  } fmar_cmd_t;

  typedef struct packed {
    logic trivial;
    logic gcd_equal;
    logic div_last;
  } fmar_status_t;

endpackage

`default_nettype wire

### hdl/fmar_ctrl.sv
// Controller state machine for the fraction multiply, add and reduce block.
// Sequences the datapath through multiply, gcd and division steps; uses fmar_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmar_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire fmar_pkg::fmar_status_t status,
  output fmar_pkg::fmar_cmd_t      cmd,
  output logic                     busy
);

  fmar_pkg::fmar_state_t state_r;
  fmar_pkg::fmar_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fmar_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fmar_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = fmar_pkg::ST_MUL_PROD;
        end
      end
      fmar_pkg::ST_MUL_PROD: state_nxt = fmar_pkg::ST_MUL_CROSS;
      fmar_pkg::ST_MUL_CROSS: state_nxt = fmar_pkg::ST_SETUP;
      fmar_pkg::ST_SETUP: begin
        state_nxt = status.trivial ? fmar_pkg::ST_FINISH : fmar_pkg::ST_GCD;
      end
      fmar_pkg::ST_GCD: begin
        if (status.gcd_equal) begin
          state_nxt = fmar_pkg::ST_DIV;
        end
      end
      fmar_pkg::ST_DIV: begin
        if (status.div_last) begin
          state_nxt = fmar_pkg::ST_FINISH;
        end
      end
      fmar_pkg::ST_FINISH: state_nxt = fmar_pkg::ST_IDLE;
      default: state_nxt = fmar_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      fmar_pkg::ST_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      fmar_pkg::ST_MUL_PROD: cmd.mul_prod = 1'b1;
      fmar_pkg::ST_MUL_CROSS: cmd.mul_cross = 1'b1;
      fmar_pkg::ST_SETUP: cmd.setup = 1'b1;
      fmar_pkg::ST_GCD: begin
        cmd.gcd_step = !status.gcd_equal;
        cmd.div_init = status.gcd_equal;
      end
      fmar_pkg::ST_DIV: cmd.div_step = 1'b1;
      fmar_pkg::ST_FINISH: cmd.finish = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

### hdl/fmar_datapath.sv
// Datapath for the fraction multiply, add and reduce block.
// Multipliers, sum, binary gcd and two serial dividers; uses fmar_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmar_datapath #(
  parameter int OPERAND_WIDTH = fmar_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire fmar_pkg::fmar_cmd_t               cmd,
  output fmar_pkg::fmar_status_t                 status,
  input  wire logic signed [OPERAND_WIDTH-1:0]   in_first_num,
  input  wire logic        [OPERAND_WIDTH-2:0]   in_first_den,
  input  wire logic signed [OPERAND_WIDTH-1:0]   in_second_num,
  input  wire logic        [OPERAND_WIDTH-2:0]   in_second_den,
  output logic                                   out_valid,
  output logic [fmar_pkg::NUM_OUT_W-1:0]         out_product_num,
  output logic [fmar_pkg::DEN_OUT_W-1:0]         out_product_den,
  output logic [fmar_pkg::NUM_OUT_W-1:0]         out_sum_num,
  output logic [fmar_pkg::DEN_OUT_W-1:0]         out_sum_den,
  output logic [fmar_pkg::NUM_OUT_W-1:0]         out_reduced_num,
  output logic [fmar_pkg::DEN_OUT_W-1:0]         out_reduced_den
);

  localparam int W = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int MW = PW - 1;
  localparam int DW = PW - 2;
  localparam int CW = $clog2(MW);
  localparam int XW = fmar_pkg::EXT_W;

  logic signed [W-1:0]  n1_r, n2_r;
  logic        [W-2:0]  d1_r, d2_r;
  logic signed [PW-1:0] pn_r, x1_r, x2_r, sn_r;
  logic        [DW-1:0] pd_r, sd_r;
  logic                 neg_r;
  logic        [MW-1:0] mag_r, ga_r, gb_r, g_r, qa_r, qb_r, rem_a_r, rem_b_r;
  logic        [CW-1:0] gk_r, cnt_r;
  logic                 out_valid_r;
  logic [fmar_pkg::NUM_OUT_W-1:0] pn_out_r, sn_out_r, rn_out_r;
  logic [fmar_pkg::DEN_OUT_W-1:0] pd_out_r, sd_out_r, rd_out_r;

  logic                 same_den;
  logic signed [PW-1:0] sn_nxt;
  logic        [DW-1:0] sd_nxt;
  logic signed [PW-1:0] mag_full;
  logic        [MW-1:0] ga_nxt, gb_nxt;
  logic        [CW-1:0] gk_nxt;
  logic        [MW:0]   trial_a, trial_b;
  logic                 ge_a, ge_b;
  logic        [MW-1:0] rem_a_nxt, rem_b_nxt;
  logic signed [PW-1:0] rn_full, rn_sel;
  logic        [MW-1:0] rd_sel;
  logic signed [XW-1:0] pn_ext, sn_ext, rn_ext;
  logic        [XW-1:0] pd_ext, sd_ext, rd_ext;

  assign same_den = (d1_r == d2_r);
  assign sn_nxt = same_den ? (PW'(n1_r) + PW'(n2_r)) : (x1_r + x2_r);
  assign sd_nxt = same_den ? DW'(d1_r) : pd_r;
  assign mag_full = pn_r[PW-1] ? -pn_r : pn_r;

  always_comb begin
    ga_nxt = ga_r;
    gb_nxt = gb_r;
    gk_nxt = gk_r;
    if (!ga_r[0] && !gb_r[0]) begin
      ga_nxt = ga_r >> 1;
      gb_nxt = gb_r >> 1;
      gk_nxt = gk_r + 1'b1;
    end else if (!ga_r[0]) begin
      ga_nxt = ga_r >> 1;
    end else if (!gb_r[0]) begin
      gb_nxt = gb_r >> 1;
    end else if (ga_r > gb_r) begin
      ga_nxt = (ga_r - gb_r) >> 1;
    end else begin
      gb_nxt = (gb_r - ga_r) >> 1;
    end
  end

  assign trial_a = {rem_a_r, qa_r[MW-1]};
  assign trial_b = {rem_b_r, qb_r[MW-1]};
  assign ge_a = (trial_a >= {1'b0, g_r});
  assign ge_b = (trial_b >= {1'b0, g_r});
  assign rem_a_nxt = ge_a ? MW'(trial_a - {1'b0, g_r}) : MW'(trial_a);
  assign rem_b_nxt = ge_b ? MW'(trial_b - {1'b0, g_r}) : MW'(trial_b);

  assign status.trivial = (pn_r == '0) || (pd_r == '0);
  assign status.gcd_equal = (ga_r == gb_r);
  assign status.div_last = (cnt_r == '0);

  assign rn_full = neg_r ? -$signed({1'b0, qa_r}) : $signed({1'b0, qa_r});

  always_comb begin
    rn_sel = rn_full;
    rd_sel = qb_r;
    if (pn_r == '0) begin
      rn_sel = '0;
      rd_sel = MW'(1);
    end else if (pd_r == '0) begin
      rn_sel = pn_r;
      rd_sel = '0;
    end
  end

  assign pn_ext = XW'(pn_r);
  assign sn_ext = XW'(sn_r);
  assign rn_ext = XW'(rn_sel);
  assign pd_ext = XW'(pd_r);
  assign sd_ext = XW'(sd_r);
  assign rd_ext = XW'(rd_sel);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n1_r <= in_first_num;
      n2_r <= in_second_num;
      d1_r <= in_first_den;
      d2_r <= in_second_den;
    end
    if (cmd.mul_prod) begin
      pn_r <= PW'(n1_r) * PW'(n2_r);
      pd_r <= DW'(d1_r) * DW'(d2_r);
    end
    if (cmd.mul_cross) begin
      x1_r <= PW'(n1_r) * PW'($signed({1'b0, d2_r}));
      x2_r <= PW'(n2_r) * PW'($signed({1'b0, d1_r}));
    end
    if (cmd.setup) begin
      sn_r  <= sn_nxt;
      sd_r  <= sd_nxt;
      neg_r <= pn_r[PW-1];
      mag_r <= mag_full[MW-1:0];
      ga_r  <= mag_full[MW-1:0];
      gb_r  <= MW'(pd_r);
      gk_r  <= '0;
    end
    if (cmd.gcd_step) begin
      ga_r <= ga_nxt;
      gb_r <= gb_nxt;
      gk_r <= gk_nxt;
    end
    if (cmd.div_init) begin
      g_r     <= ga_r << gk_r;
      qa_r    <= mag_r;
      qb_r    <= MW'(pd_r);
      rem_a_r <= '0;
      rem_b_r <= '0;
      cnt_r   <= CW'(MW - 1);
    end
    if (cmd.div_step) begin
      qa_r    <= {qa_r[MW-2:0], ge_a};
      qb_r    <= {qb_r[MW-2:0], ge_b};
      rem_a_r <= rem_a_nxt;
      rem_b_r <= rem_b_nxt;
      cnt_r   <= cnt_r - 1'b1;
    end
    if (cmd.finish) begin
      pn_out_r <= pn_ext[fmar_pkg::NUM_OUT_W-1:0];
      pd_out_r <= pd_ext[fmar_pkg::DEN_OUT_W-1:0];
      sn_out_r <= sn_ext[fmar_pkg::NUM_OUT_W-1:0];
      sd_out_r <= sd_ext[fmar_pkg::DEN_OUT_W-1:0];
      rn_out_r <= rn_ext[fmar_pkg::NUM_OUT_W-1:0];
      rd_out_r <= rd_ext[fmar_pkg::DEN_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_product_num = pn_out_r;
  assign out_product_den = pd_out_r;
  assign out_sum_num     = sn_out_r;
  assign out_sum_den     = sd_out_r;
  assign out_reduced_num = rn_out_r;
  assign out_reduced_den = rd_out_r;

endmodule

`default_nettype wire

### hdl/fraction_multiply_add_reduce.sv
// Top level of the fraction multiply, add and reduce block.
// Joins fmar_ctrl and fmar_datapath; uses fmar_pkg.
//
// Usage: drive the two fractions on the in_ ports and raise start; the
// transaction is accepted at a rising edge where start is high and busy is
// low. busy stays high until the result has been formed. The result is shown
// on the out_ ports for exactly one cycle, marked by out_valid; the receiver
// must take it then, since it cannot stall the block.
// Steps: the product, then the cross products, then the sum and gcd setup;
// then the binary gcd runs its subtract and shift steps until both operands
// match; then both serial dividers run together; then the output registers
// are loaded. When either product term is zero the gcd and division are
// skipped. One item is worked on at a time, and a new one may be started in
// the cycle in which out_valid is high.
// Reset is synchronous and active low; it returns the controller to idle and
// clears out_valid.
`timescale 1ns / 1ps
`default_nettype none

module fraction_multiply_add_reduce #(
  parameter int OPERAND_WIDTH = fmar_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [OPERAND_WIDTH-1:0]   in_first_num,
  input  wire logic        [OPERAND_WIDTH-2:0]   in_first_den,
  input  wire logic signed [OPERAND_WIDTH-1:0]   in_second_num,
  input  wire logic        [OPERAND_WIDTH-2:0]   in_second_den,
  output logic                                   out_valid,
  output logic [fmar_pkg::NUM_OUT_W-1:0]         out_product_num,
  output logic [fmar_pkg::DEN_OUT_W-1:0]         out_product_den,
  output logic [fmar_pkg::NUM_OUT_W-1:0]         out_sum_num,
  output logic [fmar_pkg::DEN_OUT_W-1:0]         out_sum_den,
  output logic [fmar_pkg::NUM_OUT_W-1:0]         out_reduced_num,
  output logic [fmar_pkg::DEN_OUT_W-1:0]         out_reduced_den
);

  fmar_pkg::fmar_cmd_t    cmd;
  fmar_pkg::fmar_status_t status;

  fmar_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  fmar_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_first_num    (in_first_num),
    .in_first_den    (in_first_den),
    .in_second_num   (in_second_num),
    .in_second_den   (in_second_den),
    .out_valid       (out_valid),
    .out_product_num (out_product_num),
    .out_product_den (out_product_den),
    .out_sum_num     (out_sum_num),
    .out_sum_den     (out_sum_den),
    .out_reduced_num (out_reduced_num),
    .out_reduced_den (out_reduced_den)
  );

endmodule

`default_nettype wire

### sim/fmar_checker.sv
// Checker for the fraction multiply, add and reduce block.
// Watches the command and result ports, predicts each result and compares it field by field.
// Depends on fmar_pkg for the output widths.
`timescale 1ns / 1ps

module fmar_checker #(
  parameter int OW = fmar_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic signed [OW-1:0]                in_first_num,
  input  logic        [OW-2:0]                in_first_den,
  input  logic signed [OW-1:0]                in_second_num,
  input  logic        [OW-2:0]                in_second_den,
  input  logic                                out_valid,
  input  logic [fmar_pkg::NUM_OUT_W-1:0]      out_product_num,
  input  logic [fmar_pkg::DEN_OUT_W-1:0]      out_product_den,
  input  logic [fmar_pkg::NUM_OUT_W-1:0]      out_sum_num,
  input  logic [fmar_pkg::DEN_OUT_W-1:0]      out_sum_den,
  input  logic [fmar_pkg::NUM_OUT_W-1:0]      out_reduced_num,
  input  logic [fmar_pkg::DEN_OUT_W-1:0]      out_reduced_den,
  output int                                  failures,
  output int                                  pending
);

  localparam int NW = fmar_pkg::NUM_OUT_W;
  localparam int DW = fmar_pkg::DEN_OUT_W;

  typedef struct {
    logic [NW-1:0] product_num;
    logic [DW-1:0] product_den;
    logic [NW-1:0] sum_num;
    logic [DW-1:0] sum_den;
    logic [NW-1:0] reduced_num;
    logic [DW-1:0] reduced_den;
  } fraction_triple_t;

  fraction_triple_t awaited_triples[$];

  function automatic longint unsigned euclid_gcd(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic fraction_triple_t multiply_add_reduce(
    logic signed [OW-1:0] n1, logic [OW-2:0] d1,
    logic signed [OW-1:0] n2, logic [OW-2:0] d2
  );
    fraction_triple_t r;
    longint a, b, c, d, pn, pd, sn, sd, rn, rd;
    longint unsigned mag, g;
    a = n1;
    b = d1;
    c = n2;
    d = d2;
    pn = a * c;
    pd = b * d;
    if (b == d) begin
      sn = a + c;
      sd = b;
    end else begin
      sn = a * d + c * b;
      sd = pd;
    end
    if (pn == 0) begin
      rn = 0;
      rd = 1;
    end else if (pd == 0) begin
      rn = pn;
      rd = pd;
    end else begin
      // The gcd is taken of the magnitude; the sign stays on the numerator.
      mag = (pn < 0) ? -pn : pn;
      g = euclid_gcd(mag, pd);
      rn = mag / g;
      if (pn < 0) begin
        rn = -rn;
      end
      rd = pd / longint'(g);
    end
    r.product_num = pn[NW-1:0];
    r.product_den = pd[DW-1:0];
    r.sum_num     = sn[NW-1:0];
    r.sum_den     = sd[DW-1:0];
    r.reduced_num = rn[NW-1:0];
    r.reduced_den = rd[DW-1:0];
    return r;
  endfunction

  task automatic check_field(input string field, input logic [63:0] expv, input logic [63:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, expv, actv);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    fraction_triple_t oldest;
    if (!rst_n) begin
      awaited_triples.delete();
    end else begin
      if (out_valid) begin
        if (awaited_triples.size() == 0) begin
          $display("%0t: result with no transaction pending, expected none, actual %0h/%0h",
                   $time, out_product_num, out_product_den);
          failures++;
        end else begin
          oldest = awaited_triples.pop_front();
          check_field("product_num", oldest.product_num, out_product_num);
          check_field("product_den", oldest.product_den, out_product_den);
          check_field("sum_num", oldest.sum_num, out_sum_num);
          check_field("sum_den", oldest.sum_den, out_sum_den);
          check_field("reduced_num", oldest.reduced_num, out_reduced_num);
          check_field("reduced_den", oldest.reduced_den, out_reduced_den);
        end
      end
      if (start && !busy) begin
        awaited_triples.push_back(multiply_add_reduce(in_first_num, in_first_den,
                                                      in_second_num, in_second_den));
      end
    end
    pending <= awaited_triples.size();
  end

endmodule

### sim/testbench.sv
// Top of the testbench for fraction_multiply_add_reduce.
// Drives directed and random fraction pairs with random gaps and gives the verdict.
// Depends on fmar_pkg, the block and fmar_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int OW = fmar_pkg::OPERAND_WIDTH_DEF;
  localparam int NW = fmar_pkg::NUM_OUT_W;
  localparam int DW = fmar_pkg::DEN_OUT_W;
  localparam int NUM_MAX = 2 ** (OW - 1) - 1;
  localparam int NUM_MIN = -(2 ** (OW - 1));
  localparam int DEN_MAX = 2 ** (OW - 1) - 1;
  localparam int RANDOM_PAIRS = 1500;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic signed [OW-1:0] in_first_num = '0;
  logic        [OW-2:0] in_first_den = '0;
  logic signed [OW-1:0] in_second_num = '0;
  logic        [OW-2:0] in_second_den = '0;
  logic                 busy;
  logic                 out_valid;
  logic [NW-1:0]        out_product_num;
  logic [DW-1:0]        out_product_den;
  logic [NW-1:0]        out_sum_num;
  logic [DW-1:0]        out_sum_den;
  logic [NW-1:0]        out_reduced_num;
  logic [DW-1:0]        out_reduced_den;
  int                   failures;
  int                   pending;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fraction_multiply_add_reduce #(
    .OPERAND_WIDTH(OW)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_first_num(in_first_num),
    .in_first_den(in_first_den),
    .in_second_num(in_second_num),
    .in_second_den(in_second_den),
    .out_valid(out_valid),
    .out_product_num(out_product_num),
    .out_product_den(out_product_den),
    .out_sum_num(out_sum_num),
    .out_sum_den(out_sum_den),
    .out_reduced_num(out_reduced_num),
    .out_reduced_den(out_reduced_den)
  );

  fmar_checker #(
    .OW(OW)
  ) i_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_first_num(in_first_num),
    .in_first_den(in_first_den),
    .in_second_num(in_second_num),
    .in_second_den(in_second_den),
    .out_valid(out_valid),
    .out_product_num(out_product_num),
    .out_product_den(out_product_den),
    .out_sum_num(out_sum_num),
    .out_sum_den(out_sum_den),
    .out_reduced_num(out_reduced_num),
    .out_reduced_den(out_reduced_den),
    .failures(failures),
    .pending(pending)
  );

  // A zero gap keeps start high so the next transaction follows directly.
  task automatic send_pair(input logic signed [OW-1:0] n1, input logic [OW-2:0] d1,
                           input logic signed [OW-1:0] n2, input logic [OW-2:0] d2,
                           input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      @(posedge clk);
      while (busy) @(posedge clk);
      repeat (gap - 1) @(posedge clk);
    end
    start <= 1'b1;
    in_first_num <= n1;
    in_first_den <= d1;
    in_second_num <= n2;
    in_second_den <= d2;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic signed [OW-1:0] extreme_num();
    case ($urandom_range(0, 4))
      0: return OW'(NUM_MIN);
      1: return OW'(-1);
      2: return OW'(0);
      3: return OW'(1);
      default: return OW'(NUM_MAX);
    endcase
  endfunction

  function automatic logic [OW-2:0] extreme_den();
    case ($urandom_range(0, 3))
      0: return (OW-1)'(1);
      1: return (OW-1)'(2);
      2: return (OW-1)'(2 ** (OW - 2));
      default: return (OW-1)'(DEN_MAX);
    endcase
  endfunction

  initial begin
    logic signed [OW-1:0] n1, n2;
    logic        [OW-2:0] d1, d2;
    int                   j, k, gap;
    bit                   back_to_back;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pair(0, 1, 0, 1, $urandom_range(0, 5));
    send_pair(NUM_MAX, DEN_MAX, NUM_MAX, DEN_MAX, $urandom_range(0, 5));
    send_pair(NUM_MIN, 1, NUM_MIN, 1, $urandom_range(0, 5));
    send_pair(NUM_MIN, DEN_MAX, NUM_MAX, 1, $urandom_range(0, 5));
    send_pair(1, DEN_MAX, 1, DEN_MAX - 1, $urandom_range(0, 5));
    send_pair(NUM_MIN, DEN_MAX - 1, NUM_MIN, DEN_MAX, $urandom_range(0, 5));
    send_pair(NUM_MAX, DEN_MAX - 1, NUM_MAX, DEN_MAX, $urandom_range(0, 5));
    send_pair(5, 7, 3, 7, $urandom_range(0, 5));
    send_pair(0, 9, NUM_MAX, 4, $urandom_range(0, 5));
    send_pair(-17, 3, 0, DEN_MAX, $urandom_range(0, 5));
    send_pair(3, 0, 5, 7, $urandom_range(0, 5));
    send_pair(-3, 4, 5, 0, $urandom_range(0, 5));
    send_pair(6, 0, -7, 0, $urandom_range(0, 5));
    send_pair(0, 0, 0, 0, $urandom_range(0, 5));
    send_pair(-12, 35, 10, 9, $urandom_range(0, 5));
    send_pair(6, 4, 10, 15, $urandom_range(0, 5));
    send_pair(-1, DEN_MAX, -1, DEN_MAX, $urandom_range(0, 5));
    send_pair(7, 1, -9, 1, $urandom_range(0, 5));
    send_pair(NUM_MAX, 1, NUM_MAX, DEN_MAX, $urandom_range(0, 5));
    send_pair(2 ** (OW - 2), 2 ** (OW - 2), -(2 ** (OW - 2)), 2, $urandom_range(0, 5));
    send_pair(-1, 1, 1, 1, $urandom_range(0, 5));
    send_pair(16'h5555, 15'h2AAA, 16'hAAAA, 15'h5555, $urandom_range(0, 5));

    back_to_back = 1'b0;
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i % 100 == 0) begin
        back_to_back = ($urandom_range(0, 3) == 0);
      end
      n1 = OW'($urandom);
      n2 = OW'($urandom);
      d1 = (OW-1)'($urandom_range(1, DEN_MAX));
      d2 = (OW-1)'($urandom_range(1, DEN_MAX));
      case ($urandom_range(0, 99)) inside
        [0:39]: begin
        end
        [40:64]: begin
          n1 = OW'(int'($urandom_range(0, 400)) - 200);
          n2 = OW'(int'($urandom_range(0, 400)) - 200);
          d1 = (OW-1)'($urandom_range(1, 200));
          d2 = (OW-1)'($urandom_range(1, 200));
        end
        [65:79]: begin
          d2 = d1;
        end
        [80:87]: begin
          // Shared factors across the pair give the reduction real work.
          j = $urandom_range(1, 100);
          k = $urandom_range(1, 100);
          n1 = OW'(k * $urandom_range(1, 300));
          d1 = (OW-1)'(j * $urandom_range(1, 300));
          n2 = OW'(j * $urandom_range(1, 300));
          d2 = (OW-1)'(k * $urandom_range(1, 300));
          if ($urandom_range(0, 1)) n1 = -n1;
          if ($urandom_range(0, 1)) n2 = -n2;
        end
        [88:92]: begin
          n1 = extreme_num();
          n2 = extreme_num();
          d1 = extreme_den();
          d2 = extreme_den();
        end
        [93:95]: begin
          if ($urandom_range(0, 1)) n1 = '0;
          else n2 = '0;
        end
        default: begin
          case ($urandom_range(0, 2))
            0: d1 = '0;
            1: d2 = '0;
            default: begin
              d1 = '0;
              d2 = '0;
            end
          endcase
        end
      endcase
      gap = back_to_back ? 0 : $urandom_range(0, 5);
      send_pair(n1, d1, n2, d2, gap);
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("[fraction_multiply_add_reduce] OK");
    end else begin
      $display("[fraction_multiply_add_reduce] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[fraction_multiply_add_reduce] ERROR");
    $finish;
  end

endmodule
